FILE: src/cit_pkg.sv
package cit_pkg;

  localparam logic [6:0]  MAX_TUPLES       = 7'd64;
  localparam logic [6:0]  TEXT_CAP         = 7'd79;
  localparam logic [12:0] SCAN_LIMIT_BYTES = 13'd6144;
  localparam logic [12:0] POSITION_MAX     = 13'h1FFF;
  localparam logic [15:0] DEFAULT_CONFIG_BASE_RESET = 16'd1024;

  localparam logic [7:0] CODE_NULL  = 8'h00;
  localparam logic [7:0] CODE_END   = 8'hFF;
  localparam logic [7:0] CODE_MANF  = 8'h20;
  localparam logic [7:0] CODE_CONF  = 8'h1A;
  localparam logic [7:0] CODE_VERS  = 8'h15;
  localparam logic [7:0] LINK_END   = 8'hFF;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [1:0] SIZE_MASK  = 2'b11;

  localparam int unsigned PADDR_W = 3;
  localparam logic REG_DEFAULT_CONFIG_BASE = 1'b0;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_LINK = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] cis_byte;
    logic       restart;
  } cis_item_t;

  typedef struct packed {
    logic        done_res;
    logic [15:0] manufacturer_id;
    logic [15:0] card_id;
    logic [15:0] config_base;
    logic [7:0]  text_char;
    logic        text_char_valid;
    logic [6:0]  text_length;
  } res_item_t;

  typedef struct packed {
    phase_t      parse_phase;
    logic [7:0]  tuple_code;
    logic [7:0]  tuple_link;
    logic [7:0]  body_index;
    logic [6:0]  tuple_count;
    logic [12:0] byte_position;
    logic [15:0] vendor_reg;
    logic [15:0] card_reg;
    logic [15:0] base_reg;
    logic [1:0]  base_size;
    logic [6:0]  text_count;
    logic [6:0]  trimmed_count;
    logic        finished;
  } parse_state_t;

endpackage

FILE: src/cit_step.sv
module cit_step (
  input  cit_pkg::parse_state_t cur,
  input  cit_pkg::cis_item_t    item,
  input  logic [15:0]           default_base,
  output cit_pkg::parse_state_t nxt,
  output cit_pkg::res_item_t    res
);

  cit_pkg::parse_state_t s;
  logic [7:0] b;
  logic [7:0] ch;
  logic       ch_valid;
  logic       close;
  logic       check;
  logic [6:0] count_inc;
  logic [8:0] index_inc;
  logic [6:0] text_inc;

  assign b         = item.cis_byte;
  assign index_inc = {1'b0, cur.body_index} + 9'd1;

  always_comb begin
    s        = cur;
    ch       = '0;
    ch_valid = 1'b0;
    close    = 1'b0;
    check    = 1'b0;
    text_inc = '0;

    if (item.restart) begin
      s             = '0;
      s.parse_phase = cit_pkg::PH_CODE;
      s.base_reg    = default_base;
    end

    if (!s.finished) begin
      if (s.byte_position < cit_pkg::POSITION_MAX) begin
        s.byte_position = s.byte_position + 13'd1;
      end
      unique case (s.parse_phase)
        cit_pkg::PH_LINK: begin
          s.tuple_link = b;
          s.body_index = '0;
          if (b == 8'd0) begin
            close = 1'b1;
            check = 1'b1;
          end else begin
            s.parse_phase = cit_pkg::PH_BODY;
          end
        end
        cit_pkg::PH_BODY: begin
          if (s.tuple_code == cit_pkg::CODE_MANF) begin
            unique case (s.body_index)
              8'd0: s.vendor_reg[7:0]  = b;
              8'd1: s.vendor_reg[15:8] = b;
              8'd2: s.card_reg[7:0]    = b;
              8'd3: s.card_reg[15:8]   = b;
              default: ;
            endcase
          end else if (s.tuple_code == cit_pkg::CODE_CONF) begin
            unique case (s.body_index)
              8'd0: s.base_size = b[1:0] & cit_pkg::SIZE_MASK;
              8'd2: s.base_reg  = {8'd0, b};
              8'd3: begin
                if (s.base_size != 2'd0) begin
                  s.base_reg[15:8] = b;
                end
              end
              default: ;
            endcase
          end else if (s.tuple_code == cit_pkg::CODE_VERS) begin
            if (s.body_index >= 8'd2 && s.text_count < cit_pkg::TEXT_CAP) begin
              ch           = (b == 8'd0) ? cit_pkg::CHAR_SPACE : b;
              ch_valid     = 1'b1;
              text_inc     = s.text_count + 7'd1;
              s.text_count = text_inc;
              if (ch != cit_pkg::CHAR_SPACE) begin
                s.trimmed_count = text_inc;
              end
            end
          end
          s.body_index = index_inc[7:0];
          if (index_inc >= {1'b0, s.tuple_link}) begin
            close = 1'b1;
            check = 1'b1;
          end
        end
        default: begin
          s.tuple_code = b;
          if (b == cit_pkg::CODE_END) begin
            s.finished = 1'b1;
          end else if (b == cit_pkg::CODE_NULL) begin
            close = 1'b1;
          end else begin
            s.parse_phase = cit_pkg::PH_LINK;
          end
        end
      endcase
    end

    count_inc = s.tuple_count + 7'd1;
    if (close) begin
      s.tuple_count = count_inc;
      s.parse_phase = cit_pkg::PH_CODE;
      if (count_inc >= cit_pkg::MAX_TUPLES) begin
        s.finished = 1'b1;
      end
      if (check && (s.tuple_link == cit_pkg::LINK_END ||
                    s.byte_position >= cit_pkg::SCAN_LIMIT_BYTES)) begin
        s.finished = 1'b1;
      end
    end

    nxt                 = s;
    res.done_res        = s.finished;
    res.manufacturer_id = s.vendor_reg;
    res.card_id         = s.card_reg;
    res.config_base     = s.base_reg;
    res.text_char       = ch;
    res.text_char_valid = ch_valid;
    res.text_length     = s.trimmed_count;
  end

endmodule

FILE: src/card_info_tuple_parser_top.sv
// Card information tuple parser. Feed the attribute-memory bytes of the card
// information structure in order on the cis channel, one per transaction; set
// restart on the first byte of each scan. Every byte gives exactly one result
// transaction carrying the IDs, config base, any version text character and
// the trimmed text length seen so far, with done_res sticky once the chain
// ends or a limit is hit. Throughput is one byte per cycle: all tuple parsing
// is a single combinational step between the parser state register and the
// result register, and a new byte is taken whenever the result register is
// empty or being drained. The result register is loaded on acceptance.
// Register 0 (byte address 0): default config base, reset 1024, loaded into
// the parser at reset and on restart.
module card_info_tuple_parser_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cis_valid,
  output logic                            cis_ready,
  input  cit_pkg::cis_item_t              cis_item,
  output logic                            res_valid,
  input  logic                            res_ready,
  output cit_pkg::res_item_t              res_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cit_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [15:0]           default_base;
  cit_pkg::parse_state_t st;
  cit_pkg::parse_state_t st_next;
  cit_pkg::parse_state_t st_reset;
  cit_pkg::res_item_t    res_next;
  logic                  accept;
  logic                  cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == cit_pkg::REG_DEFAULT_CONFIG_BASE) ?
                     {16'd0, default_base} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_base <= cit_pkg::DEFAULT_CONFIG_BASE_RESET;
    end else if (cfg_write && paddr[2] == cit_pkg::REG_DEFAULT_CONFIG_BASE) begin
      default_base <= pwdata[15:0];
    end
  end

  assign cis_ready = !res_valid || res_ready;
  assign accept    = cis_valid && cis_ready;

  cit_step u_step (
    .cur          (st),
    .item         (cis_item),
    .default_base (default_base),
    .nxt          (st_next),
    .res          (res_next)
  );

  always_comb begin
    st_reset             = '0;
    st_reset.parse_phase = cit_pkg::PH_CODE;
    st_reset.base_reg    = cit_pkg::DEFAULT_CONFIG_BASE_RESET;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= st_reset;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_item <= res_next;
    end
  end

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    st.finished && !(accept && cis_item.restart) |=> st.finished)
    else $error("parser done flag dropped without restart");

  a_done_matches: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid && res_item.done_res == st.finished)
    else $error("result done flag differs from parser state");

  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.text_char_valid |-> res_item.text_char != 8'd0)
    else $error("zero text character emitted");

  a_trim_bound: assert property (@(posedge clk) disable iff (rst)
    st.trimmed_count <= st.text_count && st.text_count <= cit_pkg::TEXT_CAP)
    else $error("text counters out of range");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !cis_ready)
    else $error("input taken while result stalled");

endmodule

FILE: tb/sv/card_info_tuple_parser_top_tb.sv
`timescale 1ns / 1ps

module card_info_tuple_parser_top_tb;

  localparam logic [7:0] OTHER_CODE = 8'h30;
  localparam logic [cit_pkg::PADDR_W-1:0] ADDR_DEFAULT_BASE =
    {cit_pkg::REG_DEFAULT_CONFIG_BASE, 2'b00};

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cis_valid;
  logic                         cis_ready;
  cit_pkg::cis_item_t           cis_item;
  logic                         res_valid;
  logic                         res_ready;
  cit_pkg::res_item_t           res_item;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [cit_pkg::PADDR_W-1:0]  paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  // parser mirror
  cit_pkg::parse_state_t        scan;
  logic [15:0]                  dflt_base;
  cit_pkg::res_item_t           pending_results [$];

  int                  mismatch_count = 0;
  int                  items_sent = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  hold_cycles = 0;

  card_info_tuple_parser_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cis_valid (cis_valid),
    .cis_ready (cis_ready),
    .cis_item  (cis_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  initial begin
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        res_ready <= 1'b0;
        hold_cycles--;
      end else begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic report_mismatch(string msg);
    $display("%0t ERROR %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void clear_scan_state();
    scan = '0;
    scan.parse_phase = cit_pkg::PH_CODE;
    scan.base_reg = dflt_base;
  endfunction

  function automatic void close_tuple(bit check_link);
    scan.tuple_count = scan.tuple_count + 7'd1;
    if (scan.tuple_count >= cit_pkg::MAX_TUPLES) scan.finished = 1'b1;
    if (check_link) begin
      if (scan.tuple_link == cit_pkg::LINK_END) scan.finished = 1'b1;
      if (scan.byte_position >= cit_pkg::SCAN_LIMIT_BYTES) scan.finished = 1'b1;
    end
    scan.parse_phase = cit_pkg::PH_CODE;
  endfunction

  function automatic cit_pkg::res_item_t predict_result(cit_pkg::cis_item_t it);
    cit_pkg::res_item_t r;
    logic [7:0] b;
    logic [7:0] idx;
    logic [7:0] ch;
    r = '0;
    b = it.cis_byte;
    if (it.restart) clear_scan_state();
    if (!scan.finished) begin
      if (scan.byte_position != cit_pkg::POSITION_MAX)
        scan.byte_position = scan.byte_position + 13'd1;
      unique case (scan.parse_phase)
        cit_pkg::PH_LINK: begin
          scan.tuple_link = b;
          scan.body_index = '0;
          if (b == 8'h00) close_tuple(1'b1);
          else scan.parse_phase = cit_pkg::PH_BODY;
        end
        cit_pkg::PH_BODY: begin
          idx = scan.body_index;
          if (scan.tuple_code == cit_pkg::CODE_MANF) begin
            if (idx == 8'd0) scan.vendor_reg[7:0] = b;
            else if (idx == 8'd1) scan.vendor_reg[15:8] = b;
            else if (idx == 8'd2) scan.card_reg[7:0] = b;
            else if (idx == 8'd3) scan.card_reg[15:8] = b;
          end else if (scan.tuple_code == cit_pkg::CODE_CONF) begin
            if (idx == 8'd0) scan.base_size = b[1:0] & cit_pkg::SIZE_MASK;
            else if (idx == 8'd2) scan.base_reg = {8'h00, b};
            else if (idx == 8'd3 && scan.base_size != 2'd0) scan.base_reg[15:8] = b;
          end else if (scan.tuple_code == cit_pkg::CODE_VERS) begin
            if (idx >= 8'd2 && scan.text_count < cit_pkg::TEXT_CAP) begin
              ch = (b == 8'h00) ? cit_pkg::CHAR_SPACE : b;
              r.text_char = ch;
              r.text_char_valid = 1'b1;
              scan.text_count = scan.text_count + 7'd1;
              if (ch != cit_pkg::CHAR_SPACE) scan.trimmed_count = scan.text_count;
            end
          end
          scan.body_index = idx + 8'd1;
          if ({1'b0, idx} + 9'd1 >= {1'b0, scan.tuple_link}) close_tuple(1'b1);
        end
        default: begin
          scan.tuple_code = b;
          if (b == cit_pkg::CODE_END) scan.finished = 1'b1;
          else if (b == cit_pkg::CODE_NULL) close_tuple(1'b0);
          else scan.parse_phase = cit_pkg::PH_LINK;
        end
      endcase
    end
    r.done_res = scan.finished;
    r.manufacturer_id = scan.vendor_reg;
    r.card_id = scan.card_reg;
    r.config_base = scan.base_reg;
    r.text_length = scan.trimmed_count;
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    cit_pkg::res_item_t want;
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result transaction %h", res_item));
        end else begin
          want = pending_results.pop_front();
          if (res_item.done_res !== want.done_res)
            report_mismatch($sformatf("done_res got %b want %b",
                                      res_item.done_res, want.done_res));
          if (res_item.manufacturer_id !== want.manufacturer_id)
            report_mismatch($sformatf("manufacturer_id got %h want %h",
                                      res_item.manufacturer_id, want.manufacturer_id));
          if (res_item.card_id !== want.card_id)
            report_mismatch($sformatf("card_id got %h want %h",
                                      res_item.card_id, want.card_id));
          if (res_item.config_base !== want.config_base)
            report_mismatch($sformatf("config_base got %h want %h",
                                      res_item.config_base, want.config_base));
          if (res_item.text_char !== want.text_char)
            report_mismatch($sformatf("text_char got %h want %h",
                                      res_item.text_char, want.text_char));
          if (res_item.text_char_valid !== want.text_char_valid)
            report_mismatch($sformatf("text_char_valid got %b want %b",
                                      res_item.text_char_valid, want.text_char_valid));
          if (res_item.text_length !== want.text_length)
            report_mismatch($sformatf("text_length got %0d want %0d",
                                      res_item.text_length, want.text_length));
        end
      end
      if (cis_valid && cis_ready) pending_results.push_back(predict_result(cis_item));
    end
  end

  task automatic send_byte(logic [7:0] b, bit first);
    cis_item <= cit_pkg::cis_item_t'{cis_byte: b, restart: first};
    cis_valid <= 1'b1;
    @(posedge clk);
    while (!cis_ready) @(posedge clk);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      cis_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_bytes(input logic [7:0] seq [$]);
    foreach (seq[i]) send_byte(seq[i], i == 0);
  endtask

  task automatic send_tuple(logic [7:0] code, logic [7:0] link, bit first);
    logic [7:0] b;
    send_byte(code, first);
    if (code == cit_pkg::CODE_NULL || code == cit_pkg::CODE_END) return;
    send_byte(link, 1'b0);
    for (int i = 0; i < int'(link); i++) begin
      b = 8'($urandom_range(255));
      if (code == cit_pkg::CODE_VERS && $urandom_range(3) == 0)
        b = $urandom_range(1) ? 8'h00 : cit_pkg::CHAR_SPACE;
      send_byte(b, 1'b0);
    end
  endtask

  task automatic send_random_scan();
    logic [7:0] code;
    int n_tuples;
    if ($urandom_range(9) == 0) begin
      // junk bytes, restart anywhere
      repeat ($urandom_range(12, 1))
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      return;
    end
    n_tuples = $urandom_range(6, 1);
    for (int t = 0; t < n_tuples; t++) begin
      case ($urandom_range(9))
        0:       code = cit_pkg::CODE_NULL;
        1, 2:    code = cit_pkg::CODE_MANF;
        3, 4:    code = cit_pkg::CODE_CONF;
        5, 6:    code = cit_pkg::CODE_VERS;
        default: code = 8'($urandom_range(254, 1));
      endcase
      send_tuple(code,
                 ($urandom_range(7) == 0) ? 8'($urandom_range(40)) : 8'($urandom_range(6)),
                 t == 0);
    end
    if ($urandom_range(1)) send_tuple(cit_pkg::CODE_END, 8'h00, 1'b0);
    if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic wait_drained();
    cis_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || res_valid) @(posedge clk);
  endtask

  task automatic write_default_base(logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_DEFAULT_BASE;
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    dflt_base = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== value)
      report_mismatch($sformatf("default_config_base read %h want %h", prdata[15:0], value));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_default_scan();
    send_bytes('{cit_pkg::CODE_NULL,
                 cit_pkg::CODE_MANF, 8'h04, 8'h34, 8'h12, 8'h78, 8'h56,
                 cit_pkg::CODE_CONF, 8'h04, 8'h03, 8'h00, 8'hCD, 8'hAB,
                 cit_pkg::CODE_VERS, 8'h06, 8'h04, 8'h01, 8'h41, 8'h00, 8'hFF, 8'h00,
                 OTHER_CODE, 8'h00,
                 cit_pkg::CODE_END, 8'h55});
  endtask

  task automatic test_short_bodies();
    send_bytes('{cit_pkg::CODE_CONF, 8'h03, 8'h00, 8'h00, 8'h77,
                 cit_pkg::CODE_CONF, 8'h04, 8'h00, 8'h00, 8'h11, 8'h22,
                 cit_pkg::CODE_CONF, 8'h02, 8'h01, 8'h09,
                 cit_pkg::CODE_MANF, 8'h01, 8'h99,
                 cit_pkg::CODE_VERS, 8'h02, 8'h41, 8'h42,
                 cit_pkg::CODE_MANF, 8'h03, 8'hAA, 8'hBB, 8'hCC});
  endtask

  task automatic test_text_cap();
    send_tuple(cit_pkg::CODE_VERS, 8'd82, 1'b1);
    send_tuple(cit_pkg::CODE_VERS, 8'd5, 1'b0);
    send_tuple(cit_pkg::CODE_END, 8'h00, 1'b0);
    send_byte(cit_pkg::CODE_VERS, 1'b0);
  endtask

  task automatic test_link_end();
    send_tuple(OTHER_CODE, cit_pkg::LINK_END, 1'b1);
    send_byte(cit_pkg::CODE_MANF, 1'b0);
  endtask

  task automatic test_tuple_limit();
    for (int i = 0; i < int'(cit_pkg::MAX_TUPLES); i++) send_byte(cit_pkg::CODE_NULL, i == 0);
    send_byte(cit_pkg::CODE_MANF, 1'b0);
    send_tuple(cit_pkg::CODE_MANF, 8'd2, 1'b1);
    for (int i = 1; i < int'(cit_pkg::MAX_TUPLES); i++) send_byte(cit_pkg::CODE_NULL, 1'b0);
    send_byte(cit_pkg::CODE_CONF, 1'b0);
  endtask

  task automatic test_backpressure();
    int start;
    start = items_sent;
    hold_cycles = 300;
    while (items_sent < start + 20) send_random_scan();
  endtask

  task automatic test_random_traffic(logic [15:0] base, int n_items);
    int start;
    wait_drained();
    write_default_base(base);
    start = items_sent;
    while (items_sent < start + n_items) send_random_scan();
  endtask

  initial begin
    rst <= 1'b1;
    cis_valid <= 1'b0;
    cis_item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    dflt_base = cit_pkg::DEFAULT_CONFIG_BASE_RESET;
    clear_scan_state();
    send_idle_pct = 13;
    recv_idle_pct = 56;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_default_scan();
    test_short_bodies();
    test_text_cap();
    test_link_end();
    test_tuple_limit();
    test_random_traffic(16'h0000, 15);

    send_idle_pct = 56;
    recv_idle_pct = 13;
    test_backpressure();
    test_random_traffic(16'hFFFF, 15);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(16'($urandom), 15);

    wait_drained();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
src/cit_pkg.sv
src/cit_step.sv
src/card_info_tuple_parser_top.sv
tb/sv/card_info_tuple_parser_top_tb.sv
